// File: hdl/cellular_automaton_grid_step_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cellular automaton grid step block
// Concurrent checks on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef CELLULAR_AUTOMATON_GRID_STEP_ASSERT_SVH
`define CELLULAR_AUTOMATON_GRID_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define CAGS_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define CAGS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// consequent holds in the cycle after the antecedent
`define CAGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CAGS_ASSERT_HOLD(label, cond, msg)
`define CAGS_ASSERT_IMPL(label, ante, cons, msg)
`define CAGS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/cags_pkg.sv
// ---------------------------------------------------------------------------
// Cellular automaton grid step package
// Field widths, slot codes, position flags and the survival rule.
// ---------------------------------------------------------------------------
package cags_pkg;

   // width of the grid side register
   localparam int CFG_W = 11;
   // width of the emitted row and column indexes
   localparam int POS_W = 10;
   // grid side after reset
   localparam int SIDE_RESET = 960;

   // result slots of one input cell, emitted lowest first
   localparam int SLOT_LAG   = 0;  // cell one row above the input
   localparam int SLOT_LEFT  = 1;  // last row: cell left of the input
   localparam int SLOT_FINAL = 2;  // final input: the input cell itself
   localparam int SLOT_N     = 3;

   typedef logic [CFG_W-1:0] cfg_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [2:0]       sum_type;

   // position of an accepted cell within the frame
   typedef struct packed {
      logic row_ge1;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic last_row;
      logic row_end;
   } pos_flags_type;

   // live only for a neighborhood sum of two or three
   function automatic logic rule(input sum_type sum);
      rule = (sum == 3'd2) || (sum == 3'd3);
   endfunction

endpackage

// File: hdl/cags_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Read-first, registered read data held when no read is issued.
// ---------------------------------------------------------------------------
module cags_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read; a read of the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cellular_automaton_grid_step.sv
// Order: an accepted cell waits in the input stage, and its results pass from there
//   through the result register one per cycle unless rsp_ready holds them back.
// Throughput: one cell per cycle on rows with one result or none, unless stalled;
//   a last-row cell gives up to three results; the single result register sets this.
// Reset: synchronous, clears position counters and side to 960; row stores need no clear.
// ---------------------------------------------------------------------------
// Cellular automaton grid step
// Streams raster-order cells through two swapped row RAMs and emits the
// next generation of each cell under a von Neumann survival rule.
// ---------------------------------------------------------------------------
`include "cellular_automaton_grid_step_assert.svh"

module cellular_automaton_grid_step #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   // input cells
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cell_in,
   // results
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_next_state,
   output cags_pkg::pos_type       rsp_out_row,
   output cags_pkg::pos_type       rsp_out_col,
   output logic                    rsp_frame_end,
   // grid side register
   input  logic                    csr_wr_en,
   input  cags_pkg::cfg_type       csr_wr_data
);

   localparam int CW     = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int EW     = (SIDE_W > cags_pkg::CFG_W) ? SIDE_W : cags_pkg::CFG_W;
   localparam int SIDE_RST = (cags_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                               : cags_pkg::SIDE_RESET;

   // frame position and configuration
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [CW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic              bank_ff, bank_in;
   logic              first_x_ff, last_x_ff, last2_x_ff;

   // input stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [cags_pkg::SLOT_N-1:0] s1_pend_ff, s1_pend_in;
   logic                        s1_x_ff;
   logic [CW-1:0]               s1_row_ff, s1_col_ff;
   cags_pkg::pos_flags_type     s1_flag_ff, flag_in;
   logic                        s1_bank_ff;
   logic                        s1_pl_ff, s1_pc_ff, s1_xl1_ff, s1_xl2_ff;
   logic                        pc_in, pl_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_state_ff, rsp_fe_ff;
   cags_pkg::pos_type rsp_row_ff, rsp_col_ff;

   // RAM ports
   logic          rd0, rd1;
   logic [CW-1:0] col_next;
   logic          accept;

   // result selection
   logic                        p_next, o_cur, p_rd_now;
   cags_pkg::sum_type           sum_lag, sum_left, sum_final;
   logic [cags_pkg::SLOT_N-1:0] pick, pend_after;
   logic                        out_free, load_out, s1_done;
   logic                        sel_state, sel_fe;
   logic [CW-1:0]               sel_row, sel_col;
   logic [EW-1:0]               cfg_wide, cfg_eff;

   assign accept   = req_valid && req_ready;
   assign col_next = col_ff + 1'b1;

   // clamp the written side into one through MAX_SIDE
   always_comb begin
      cfg_wide = EW'(csr_wr_data);
      if (cfg_wide == '0) begin
         cfg_eff = EW'(1);
      end else if (cfg_wide > EW'(MAX_SIDE)) begin
         cfg_eff = EW'(MAX_SIDE);
      end else begin
         cfg_eff = cfg_wide;
      end
      side_in = SIDE_W'(cfg_eff);
   end

   // classify the position of the cell now at the input
   always_comb begin
      flag_in.row_ge1  = (row_ff != '0);
      flag_in.row_ge2  = (row_ff > CW'(1));
      flag_in.col_ge1  = (col_ff != '0);
      flag_in.col_ge2  = (col_ff > CW'(1));
      flag_in.last_row = (SIDE_W'(row_ff) + 1'b1 == side_ff);
      flag_in.row_end  = (SIDE_W'(col_ff) + 1'b1 == side_ff);
   end

   // advance the position; a row end swaps the stores, a side write restarts
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      if (csr_wr_en) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (flag_in.row_end) begin
            col_in  = '0;
            row_in  = flag_in.last_row ? '0 : row_ff + 1'b1;
            bank_in = !bank_ff;
         end else begin
            col_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(SIDE_RST);
         row_ff  <= '0;
         col_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            side_ff <= side_in;
         end
         row_ff  <= row_in;
         col_ff  <= col_in;
         bank_ff <= bank_in;
      end
   end

   // row stores: the bank selected by bank_ff takes the current row
   cags_ram #(.WIDTH(1), .DEPTH(MAX_SIDE)) u_ram0 (
      .clock   (clock),
      .wr_en   (accept && !bank_ff),
      .wr_addr (col_ff),
      .wr_data (req_cell_in),
      .rd_en   (accept),
      .rd_addr (bank_ff ? col_next : col_ff),
      .rd_data (rd0)
   );

   cags_ram #(.WIDTH(1), .DEPTH(MAX_SIDE)) u_ram1 (
      .clock   (clock),
      .wr_en   (accept && bank_ff),
      .wr_addr (col_ff),
      .wr_data (req_cell_in),
      .rd_en   (accept),
      .rd_addr (bank_ff ? col_ff : col_next),
      .rd_data (rd1)
   );

   // slide the window over the row above
   assign p_rd_now = bank_ff ? rd0 : rd1;
   assign pc_in    = flag_in.col_ge1 ? p_rd_now : first_x_ff;
   assign pl_in    = flag_in.col_ge1 ? s1_pc_ff : 1'b0;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff    <= req_cell_in;
         s1_row_ff  <= row_ff;
         s1_col_ff  <= col_ff;
         s1_flag_ff <= flag_in;
         s1_bank_ff <= bank_ff;
         s1_pc_ff   <= pc_in;
         s1_pl_ff   <= pl_in;
         s1_xl1_ff  <= last_x_ff;
         s1_xl2_ff  <= last2_x_ff;
         last_x_ff  <= req_cell_in;
         last2_x_ff <= last_x_ff;
         if (!flag_in.col_ge1) begin
            first_x_ff <= req_cell_in;
         end
      end
   end

   // neighborhood sums of the three possible result cells
   assign o_cur  = s1_bank_ff ? rd1 : rd0;
   assign p_next = s1_bank_ff ? rd0 : rd1;

   always_comb begin
      sum_lag = 3'(s1_pc_ff) + 3'(s1_x_ff)
              + 3'(s1_flag_ff.col_ge1 & s1_pl_ff)
              + 3'(!s1_flag_ff.row_end & p_next)
              + 3'(s1_flag_ff.row_ge2 & o_cur);
      sum_left = 3'(s1_xl1_ff) + 3'(s1_x_ff)
               + 3'(s1_flag_ff.col_ge2 & s1_xl2_ff)
               + 3'(s1_flag_ff.row_ge1 & s1_pl_ff);
      sum_final = 3'(s1_x_ff)
                + 3'(s1_flag_ff.col_ge1 & s1_xl1_ff)
                + 3'(s1_flag_ff.row_ge1 & s1_pc_ff);
   end

   // pick the lowest pending result slot
   always_comb begin
      pick      = '0;
      sel_state = cags_pkg::rule(sum_final);
      sel_row   = s1_row_ff;
      sel_col   = s1_col_ff;
      sel_fe    = 1'b1;
      if (s1_pend_ff[cags_pkg::SLOT_LAG]) begin
         pick[cags_pkg::SLOT_LAG] = 1'b1;
         sel_state = cags_pkg::rule(sum_lag);
         sel_row   = s1_row_ff - 1'b1;
         sel_fe    = 1'b0;
      end else if (s1_pend_ff[cags_pkg::SLOT_LEFT]) begin
         pick[cags_pkg::SLOT_LEFT] = 1'b1;
         sel_state = cags_pkg::rule(sum_left);
         sel_col   = s1_col_ff - 1'b1;
         sel_fe    = 1'b0;
      end else if (s1_pend_ff[cags_pkg::SLOT_FINAL]) begin
         pick[cags_pkg::SLOT_FINAL] = 1'b1;
      end
   end

   // drain the input stage one result per cycle into the result register while it is free
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_out   = s1_valid_ff && (s1_pend_ff != '0) && out_free;
   assign pend_after = load_out ? (s1_pend_ff & ~pick) : s1_pend_ff;
   assign s1_done    = s1_valid_ff && (pend_after == '0);
   assign req_ready  = !s1_valid_ff || s1_done;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pend_in  = pend_after;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pend_in[cags_pkg::SLOT_LAG]   = flag_in.row_ge1;
         s1_pend_in[cags_pkg::SLOT_LEFT]  = flag_in.last_row && flag_in.col_ge1;
         s1_pend_in[cags_pkg::SLOT_FINAL] = flag_in.last_row && flag_in.row_end;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
         s1_pend_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_pend_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_pend_ff  <= s1_pend_in;
      end
   end

   // hold the result until the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_state_ff <= sel_state;
         rsp_row_ff   <= cags_pkg::pos_type'(sel_row);
         rsp_col_ff   <= cags_pkg::pos_type'(sel_col);
         rsp_fe_ff    <= sel_fe;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_state = rsp_state_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_end  = rsp_fe_ff;

   // checks
   `CAGS_ASSERT_HOLD(a_pos_in_range, (SIDE_W'(col_ff) < side_ff) && (SIDE_W'(row_ff) < side_ff), "position outside grid")
   `CAGS_ASSERT_IMPL(a_frame_end_corner, rsp_valid_ff && rsp_fe_ff, rsp_row_ff == rsp_col_ff, "frame end off corner")
   `CAGS_ASSERT_HOLD(a_idle_no_pend, s1_valid_ff || (s1_pend_ff == '0), "pending result in empty stage")
   `CAGS_ASSERT_NEXT(a_accept_loads, accept, s1_valid_ff, "accepted cell lost")
   `CAGS_ASSERT_NEXT(a_row_end_swap, accept && flag_in.row_end, bank_ff != $past(bank_ff), "stores not swapped")

endmodule

// File: bench/tb_cellular_automaton_grid_step.sv
// ---------------------------------------------------------------------------
// Testbench for the cellular automaton grid step block
// Streams raster-order cell frames of many grid sides through the block,
// predicts every next-generation cell in a local model with its own row
// stores, and compares each result transaction field by field in order.
// ---------------------------------------------------------------------------
module tb_cellular_automaton_grid_step;

   localparam int          MAX_SIDE     = 1024;
   localparam int          RANDOM_CELLS = 285;
   localparam int          PROBE_CELLS  = 40;
   localparam int          STALL_LIMIT  = 1000;

   // one emitted cell as the block presents it
   typedef struct packed {
      logic              next_state;
      cags_pkg::pos_type row;
      cags_pkg::pos_type col;
      logic              frame_end;
   } grid_cell_type;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic              req_cell_in    = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic              rsp_next_state;
   cags_pkg::pos_type rsp_out_row;
   cags_pkg::pos_type rsp_out_col;
   logic              rsp_frame_end;
   logic              csr_wr_en      = 1'b0;
   cags_pkg::cfg_type csr_wr_data    = '0;

   // model state: side register, two row stores with a swap spare, input position
   cags_pkg::cfg_type side_reg = cags_pkg::cfg_type'(cags_pkg::SIDE_RESET);
   bit                upper_row [MAX_SIDE];
   bit                filling_row [MAX_SIDE];
   bit                spare_row [MAX_SIDE];
   int unsigned       row_pos  = 0;
   int unsigned       col_pos  = 0;
   grid_cell_type     next_gen_q [$];

   bit          steady      = 1'b0;
   int unsigned mismatches  = 0;
   int unsigned stall_left  = 0;
   int unsigned quiet_count = 0;

   cellular_automaton_grid_step #(
      .MAX_SIDE(MAX_SIDE)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_in    (req_cell_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_state (rsp_next_state),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_end  (rsp_frame_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   // queue one expected cell; live only for a sum of two or three
   function automatic void expect_cell(input int unsigned sum, input int unsigned r,
                                       input int unsigned c, input logic last);
      grid_cell_type entry;
      entry.next_state = (sum == 2) || (sum == 3);
      entry.row        = cags_pkg::pos_type'(r);
      entry.col        = cags_pkg::pos_type'(c);
      entry.frame_end  = last;
      next_gen_q.push_back(entry);
   endfunction

   // advance the grid model by one accepted cell
   function automatic void advance_grid(input logic state_in);
      int unsigned s;
      int unsigned r;
      int unsigned c;
      int unsigned x;
      int unsigned sum;
      s = side_reg;
      if (s == 0) s = 1;
      if (s > MAX_SIDE) s = MAX_SIDE;
      r = row_pos;
      c = col_pos;
      x = state_in;
      if (r >= s || c >= s) begin
         r = 0;
         c = 0;
      end
      // cell one row above is now complete
      if (r >= 1) begin
         sum = upper_row[c] + x;
         if (c > 0) sum += upper_row[c-1];
         if (c + 1 < s) sum += upper_row[c+1];
         if (r >= 2) sum += filling_row[c];
         expect_cell(sum, r - 1, c, 1'b0);
      end
      filling_row[c] = state_in;
      // last row: flush the left neighbor, and the final cell itself
      if (r + 1 == s) begin
         if (c >= 1) begin
            sum = filling_row[c-1] + x;
            if (c >= 2) sum += filling_row[c-2];
            if (r >= 1) sum += upper_row[c-1];
            expect_cell(sum, r, c - 1, 1'b0);
         end
         if (c + 1 == s) begin
            sum = x;
            if (c >= 1) sum += filling_row[c-1];
            if (r >= 1) sum += upper_row[c];
            expect_cell(sum, r, c, 1'b1);
         end
      end
      // step position; swap the stores at row end
      if (c + 1 == s) begin
         spare_row   = upper_row;
         upper_row   = filling_row;
         filling_row = spare_row;
         col_pos     = 0;
         row_pos     = (r + 1 == s) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // send one cell transaction, with an optional idle burst first
   task automatic send_cell(input logic state_in);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cell_in <= state_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_grid(state_in);
   endtask

   // drop valid, wait for all results, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (next_gen_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the side register; this restarts the frame
   task automatic write_side(input cags_pkg::cfg_type side);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= side;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      side_reg     = side;
      row_pos      = 0;
      col_pos      = 0;
   endtask

   task automatic send_pattern(input int unsigned count, input logic [63:0] bits);
      for (int i = 0; i < count; i++) send_cell(bits[i]);
   endtask

   // side after reset: the first row of a 960 grid emits nothing
   task automatic test_reset_side();
      repeat (PROBE_CELLS) send_cell($urandom_range(0, 1));
   endtask

   // one by one grid, also reached through side zero
   task automatic test_tiny_grids();
      drain();
      write_side(cags_pkg::cfg_type'(1));
      send_pattern(2, 64'b01);
      drain();
      write_side(cags_pkg::cfg_type'(0));
      send_pattern(1, 64'b1);
   endtask

   // fixed patterns covering high and low neighborhood sums
   task automatic test_small_patterns();
      drain();
      write_side(cags_pkg::cfg_type'(2));
      send_pattern(4, 64'hf);
      drain();
      write_side(cags_pkg::cfg_type'(3));
      send_pattern(9, 64'h1ff);
      send_pattern(9, 64'b000_010_000);
   endtask

   // widest grid and an oversized side: first row only, no results
   task automatic test_wide_grid();
      drain();
      write_side(cags_pkg::cfg_type'(MAX_SIDE));
      repeat (PROBE_CELLS) send_cell($urandom_range(0, 1));
      drain();
      write_side('1);
      repeat (PROBE_CELLS) send_cell($urandom_range(0, 1));
   endtask

   // random sides and densities; mostly whole frames, some cut short
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned side;
      int unsigned span;
      int unsigned cells;
      int unsigned density;
      int unsigned pick;
      sent = 0;
      while (sent < RANDOM_CELLS) begin
         if (sent > RANDOM_CELLS * 2 / 3) steady = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick == 0) side = 0;
         else if (pick == 1) side = $urandom_range(9, 14);
         else side = $urandom_range(1, 8);
         span = (side == 0) ? 1 : side;
         cells = span * span * $urandom_range(1, 2);
         if ($urandom_range(0, 6) == 0) cells = $urandom_range(1, span * span);
         if (cells > RANDOM_CELLS - sent) cells = RANDOM_CELLS - sent;
         density = $urandom_range(0, 4) * 25;
         drain();
         write_side(cags_pkg::cfg_type'(side));
         repeat (cells) send_cell($urandom_range(0, 99) < density);
         sent += cells;
      end
   endtask

   // check each result transaction and drive ready with random stalls
   always @(posedge clock) begin
      grid_cell_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (next_gen_q.size() == 0) begin
            mismatches++;
            $error("unexpected result at row %0d col %0d", rsp_out_row, rsp_out_col);
         end else begin
            want = next_gen_q.pop_front();
            check_field("next_state", want.next_state, rsp_next_state);
            check_field("out_row", want.row, rsp_out_row);
            check_field("out_col", want.col, rsp_out_col);
            check_field("frame_end", want.frame_end, rsp_frame_end);
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if (!reset && !steady && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count + 1 >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_side();
      test_tiny_grids();
      test_small_patterns();
      test_wide_grid();
      test_random_frames();
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && next_gen_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/cags_pkg.sv
hdl/cags_ram.sv
hdl/cellular_automaton_grid_step.sv
bench/tb_cellular_automaton_grid_step.sv
